@@ hw/rtl/bptl_pkg.sv @@
// ----------------------------------------------------------------------------
// bptl_pkg
// Shared types and constants for the binary paper-tape loader.
// ----------------------------------------------------------------------------
package bptl_pkg;

    // Loader phase
    typedef enum logic [1:0] {
        PH_LEADER = 2'd0,   // skipping leader
        PH_LOW    = 2'd1,   // high char seen, waiting for low char
        PH_NEXT   = 2'd2,   // word held until the following char is seen
        PH_DONE   = 2'd3    // loading ended
    } phase_t;

    // Load status codes
    localparam logic [1:0] ST_LOADING = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_EOT     = 2'd2;
    localparam logic [1:0] ST_CSUM    = 2'd3;

    // Special tape characters
    localparam logic [7:0] CH_RUBOUT  = 8'o377;
    localparam logic [7:0] CH_TRAILER = 8'o200;
    localparam logic [7:0] CH_BLANK   = 8'o000;

    localparam int unsigned FIELD_W  = 3;
    localparam int unsigned ORIGIN_W = 12;
    localparam int unsigned WORD_W   = 13;

    // One result of the loader
    typedef struct packed {
        logic                          write_valid;
        logic [FIELD_W+ORIGIN_W-1:0]   write_address;
        logic [ORIGIN_W-1:0]           write_data;
        logic                          finished;
        logic [1:0]                    load_status;
    } result_t;

endpackage

@@ hw/rtl/binary_paper_tape_loader.sv @@
// ----------------------------------------------------------------------------
// binary_paper_tape_loader
// Binary-format paper-tape loader: turns tape characters into memory writes.
// ----------------------------------------------------------------------------
// Input channel (s_): one request per tape character, or an end-of-tape mark
// with s_tape_end high. Result channel (m_): exactly one result per request,
// carrying an optional memory write (field:origin address, 12-bit data) and
// the load status.
// The result is registered and shows on m_ in the cycle after the request is accepted.
// Throughput: one request per cycle while m_ready is high; the character update
// is a single pass through the state logic into the result register.
// When the receiver stalls, the result register holds and s_ready drops
// until the held result is taken; s_ready stays high while m_ready is high.
// Reset (aresetn low, synchronous) returns the loader to leader skipping with
// cleared sum, origin and fields and drops m_valid.
// Once loading ends (success, premature end of tape or checksum error) every
// further request is answered with finished set and the same status.
// ----------------------------------------------------------------------------
module binary_paper_tape_loader (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_tape_char,
    input  logic        s_tape_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_valid,
    output logic [14:0] m_write_address,
    output logic [11:0] m_write_data,
    output logic        m_finished,
    output logic [1:0]  m_load_status
);

    logic               accept;
    logic               m_valid_reg;
    bptl_pkg::result_t  step_res;
    bptl_pkg::result_t  res_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    bptl_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept),
        .tape_char (s_tape_char),
        .tape_end  (s_tape_end),
        .res       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= step_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_write_valid   = res_reg.write_valid;
    assign m_write_address = res_reg.write_address;
    assign m_write_data    = res_reg.write_data;
    assign m_finished      = res_reg.finished;
    assign m_load_status   = res_reg.load_status;

endmodule

@@ hw/rtl/bptl_core.sv @@
// ----------------------------------------------------------------------------
// bptl_core
// Loader state and the per-character update; gives the result of the
// character presented on step.
// ----------------------------------------------------------------------------
module bptl_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [7:0]         tape_char,
    input  logic               tape_end,
    output bptl_pkg::result_t  res
);

    bptl_pkg::phase_t phase_reg, phase_next;
    logic        skip_reg,      skip_next;
    logic [7:0]  high_char_reg, high_char_next;
    logic [12:0] pend_word_reg, pend_word_next;
    logic [7:0]  pend_high_reg, pend_high_next;
    logic [7:0]  pend_low_reg,  pend_low_next;
    logic [11:0] sum_reg,       sum_next;
    logic [11:0] origin_reg,    origin_next;
    logic [2:0]  afield_reg,    afield_next;
    logic [2:0]  nfield_reg,    nfield_next;
    logic        sect_done_reg, sect_done_next;
    logic [1:0]  status_reg,    status_next;
    logic [11:0] csum_diff;

    assign csum_diff = sum_reg - pend_word_reg[11:0];

    always_comb begin
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        high_char_next = high_char_reg;
        pend_word_next = pend_word_reg;
        pend_high_next = pend_high_reg;
        pend_low_next  = pend_low_reg;
        sum_next       = sum_reg;
        origin_next    = origin_reg;
        afield_next    = afield_reg;
        nfield_next    = nfield_reg;
        sect_done_next = sect_done_reg;
        status_next    = status_reg;
        res            = '0;

        if (step && phase_reg != bptl_pkg::PH_DONE) begin
            if (tape_end) begin
                phase_next = bptl_pkg::PH_DONE;
                if (phase_reg == bptl_pkg::PH_LEADER && sect_done_reg) begin
                    status_next = bptl_pkg::ST_OK;
                end else begin
                    status_next = bptl_pkg::ST_EOT;
                end
            end else if (skip_reg) begin
                skip_next = 1'b0;
            end else if (tape_char == bptl_pkg::CH_RUBOUT) begin
                skip_next = 1'b1;
            end else if (tape_char > bptl_pkg::CH_TRAILER) begin
                nfield_next = tape_char[5:3];
            end else begin
                case (phase_reg)
                    bptl_pkg::PH_LEADER: begin
                        if (tape_char != bptl_pkg::CH_BLANK &&
                            tape_char != bptl_pkg::CH_TRAILER) begin
                            high_char_next = tape_char;
                            phase_next     = bptl_pkg::PH_LOW;
                        end
                    end
                    bptl_pkg::PH_LOW: begin
                        pend_high_next = high_char_reg;
                        pend_low_next  = tape_char;
                        // trailer as a low char lands in bit 7 of the word
                        pend_word_next = {high_char_reg[6:0], 6'b0} | {5'b0, tape_char};
                        phase_next     = bptl_pkg::PH_NEXT;
                    end
                    default: begin
                        if (tape_char == bptl_pkg::CH_TRAILER) begin
                            if (csum_diff != 12'd0) begin
                                phase_next  = bptl_pkg::PH_DONE;
                                status_next = bptl_pkg::ST_CSUM;
                            end else begin
                                sect_done_next = 1'b1;
                                sum_next       = '0;
                                origin_next    = '0;
                                afield_next    = '0;
                                nfield_next    = '0;
                                phase_next     = bptl_pkg::PH_LEADER;
                            end
                        end else begin
                            sum_next = sum_reg + {4'b0, pend_high_reg}
                                               + {4'b0, pend_low_reg};
                            if (pend_word_reg[12]) begin
                                // channel 7 set: origin word
                                origin_next = pend_word_reg[11:0];
                            end else begin
                                res.write_valid   = 1'b1;
                                res.write_address = {afield_reg, origin_reg};
                                res.write_data    = pend_word_reg[11:0];
                                origin_next       = origin_reg + 12'd1;
                            end
                            afield_next    = nfield_reg;
                            high_char_next = tape_char;
                            phase_next     = bptl_pkg::PH_LOW;
                        end
                    end
                endcase
            end
        end

        res.finished    = (phase_next == bptl_pkg::PH_DONE);
        res.load_status = status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= bptl_pkg::PH_LEADER;
            skip_reg      <= 1'b0;
            high_char_reg <= '0;
            pend_word_reg <= '0;
            pend_high_reg <= '0;
            pend_low_reg  <= '0;
            sum_reg       <= '0;
            origin_reg    <= '0;
            afield_reg    <= '0;
            nfield_reg    <= '0;
            sect_done_reg <= 1'b0;
            status_reg    <= bptl_pkg::ST_LOADING;
        end else begin
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            high_char_reg <= high_char_next;
            pend_word_reg <= pend_word_next;
            pend_high_reg <= pend_high_next;
            pend_low_reg  <= pend_low_next;
            sum_reg       <= sum_next;
            origin_reg    <= origin_next;
            afield_reg    <= afield_next;
            nfield_reg    <= nfield_next;
            sect_done_reg <= sect_done_next;
            status_reg    <= status_next;
        end
    end

endmodule

@@ hw/rtl/bptl_checker.sv @@
// ----------------------------------------------------------------------------
// bptl_checker
// Port-level checks for the binary paper-tape loader.
// ----------------------------------------------------------------------------
module bptl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_write_valid,
    input logic [14:0] m_write_address,
    input logic [11:0] m_write_data,
    input logic        m_finished,
    input logic [1:0]  m_load_status
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_write_data)
            && $stable(m_write_address) && $stable(m_load_status))
        else $error("result changed while stalled");

    // an accepted request shows its result on the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request gave no result");

    // once finished, later results stay finished
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished |=> !m_valid || m_finished)
        else $error("finished dropped");

    // status is nonzero exactly when finished
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_finished == (m_load_status != bptl_pkg::ST_LOADING)))
        else $error("status and finished disagree");

    // a write never comes with the end of loading; no write means zero payload
    a_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_write_valid && !m_finished) ||
                    (!m_write_valid && m_write_address == 15'd0 && m_write_data == 12'd0))
        else $error("bad write payload");

endmodule

bind binary_paper_tape_loader bptl_checker u_bptl_checker (.*);
